// File: rtl/wls_pkg.sv
// ----------------------------------------------------------------------------
// wls_pkg
// shared types, constants and coordinate helpers for the wrapped 3d line
// stepper
// ----------------------------------------------------------------------------
`default_nettype none

package wls_pkg;

	localparam int NUM_TILES = 3072;
	localparam int COORD_W   = 12;
	localparam int SPAN_W    = 11;
	localparam int DIST_W    = 13;
	localparam int INC_W     = 4;
	localparam int SUM_W     = 15;
	localparam int QUOT_W    = 4;
	localparam int DCNT_W    = 2;
	localparam int STAT_W    = 2;
	localparam int DELTA_W   = COORD_W + 2;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} wls_op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_STARTED  = 2'd0,
		ST_NOWHERE  = 2'd1,
		ST_STEPPED  = 2'd2,
		ST_FINISHED = 2'd3
	} wls_status_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} wls_axis_t;

	typedef struct packed {
		logic              neg;
		logic [SPAN_W-1:0] mag;
	} wls_delta_t;

	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  dividend;
		logic [SPAN_W-1:0] divisor;
	} wls_div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
		logic [SPAN_W-1:0] rem;
	} wls_div_rsp_t;

	function automatic logic [COORD_W-1:0] wls_reduce(input logic [COORD_W-1:0] v);
		logic [COORD_W-1:0] r;
		if (v >= COORD_W'(NUM_TILES)) begin
			r = v - COORD_W'(NUM_TILES);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic wls_delta_t wls_delta(input logic [COORD_W-1:0] from,
		input logic [COORD_W-1:0] to);
		logic signed [DELTA_W-1:0] diff;
		logic signed [DELTA_W-1:0] absd;
		wls_delta_t d;
		diff = $signed({2'b00, to}) - $signed({2'b00, from});
		if (diff >= $signed(DELTA_W'(NUM_TILES / 2))) begin
			diff = diff - $signed(DELTA_W'(NUM_TILES));
		end else if (diff < -$signed(DELTA_W'(NUM_TILES / 2))) begin
			diff = diff + $signed(DELTA_W'(NUM_TILES));
		end
		absd = diff[DELTA_W-1] ? -diff : diff;
		d.neg = diff[DELTA_W-1];
		d.mag = absd[SPAN_W-1:0];
		return d;
	endfunction

	function automatic logic [COORD_W-1:0] wls_move(input logic [COORD_W-1:0] c,
		input logic [INC_W-1:0] amount, input logic down);
		logic [COORD_W:0] t;
		if (down) begin
			t = {1'b0, c} - (COORD_W+1)'(amount);
			if (t[COORD_W]) begin
				t = t + (COORD_W+1)'(NUM_TILES);
			end
		end else begin
			t = {1'b0, c} + (COORD_W+1)'(amount);
			if (t >= (COORD_W+1)'(NUM_TILES)) begin
				t = t - (COORD_W+1)'(NUM_TILES);
			end
		end
		return t[COORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/wls_ifs.sv
// ----------------------------------------------------------------------------
// wls channel interfaces
// request, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface wls_req_if;
	import wls_pkg::*;
	logic               valid;
	logic               ready;
	logic               op;
	logic [COORD_W-1:0] src_x;
	logic [COORD_W-1:0] src_y;
	logic [COORD_W-1:0] src_z;
	logic [COORD_W-1:0] dst_x;
	logic [COORD_W-1:0] dst_y;
	logic [COORD_W-1:0] dst_z;
	modport source (output valid, op, src_x, src_y, src_z, dst_x, dst_y, dst_z,
		input ready);
	modport sink (input valid, op, src_x, src_y, src_z, dst_x, dst_y, dst_z,
		output ready);
endinterface

interface wls_rsp_if;
	import wls_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] tile_x;
	logic [COORD_W-1:0] tile_y;
	logic [COORD_W-1:0] tile_z;
	logic [STAT_W-1:0]  status;
	logic               last_step;
	modport source (output valid, tile_x, tile_y, tile_z, status, last_step,
		input ready);
	modport sink (input valid, tile_x, tile_y, tile_z, status, last_step,
		output ready);
endinterface

interface wls_cfg_if;
	import wls_pkg::*;
	logic             valid;
	logic             ready;
	logic [INC_W-1:0] step_increment;
	modport source (output valid, step_increment, input ready);
	modport sink (input valid, step_increment, output ready);
endinterface

`default_nettype wire

// File: rtl/wrapped_3d_line_stepper_unit.sv
// ----------------------------------------------------------------------------
// wrapped_3d_line_stepper_unit
// walks a 3d tile line on a wrapped world, one tile group per step transaction
// ----------------------------------------------------------------------------
// sequence: a start transaction runs calc then done; a step runs calc,
// div_a and div_b (two divisions in the shared divider), move and done;
// a finished step runs calc then done; one transaction at a time, and the
// next is accepted the cycle after the result is in the output register
// reset: clears the current tile, path state and step increment (to 1)
// ----------------------------------------------------------------------------
`default_nettype none

module wrapped_3d_line_stepper_unit
	import wls_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	wls_req_if.sink   req,
	wls_rsp_if.source rsp,
	wls_cfg_if.sink   cfg
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CALC  = 6'b000010,
		S_DIV_A = 6'b000100,
		S_DIV_B = 6'b001000,
		S_MOVE  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t             state_q;
	logic [INC_W-1:0]   inc_q;
	logic               op_q;
	logic [COORD_W-1:0] src_x_q, src_y_q, src_z_q;
	logic [COORD_W-1:0] dst_x_q, dst_y_q, dst_z_q;
	logic [COORD_W-1:0] cur_x_q, cur_y_q, cur_z_q;
	wls_axis_t          major_q;
	logic [2:0]         signs_q;
	logic [SPAN_W-1:0]  major_span_q, minor_a_q, minor_b_q;
	logic [SPAN_W-1:0]  rem_a_q, rem_b_q;
	logic [DIST_W-1:0]  dist_q;
	logic [QUOT_W-1:0]  ma_q;
	wls_status_t        status_q;
	logic               last_q;
	logic               out_valid_q;
	logic [COORD_W-1:0] out_x_q, out_y_q, out_z_q;
	logic [STAT_W-1:0]  out_status_q;
	logic               out_last_q;

	logic               accept;
	logic               load_out;
	logic [INC_W-1:0]   inc_eff;
	logic [COORD_W-1:0] sx, sy, sz, ex, ey, ez;
	wls_delta_t         dx, dy, dz;
	logic               nowhere;
	wls_axis_t          new_major;
	logic [SPAN_W-1:0]  new_major_span, new_minor_a, new_minor_b;
	logic [SPAN_W-1:0]  mul_minor, mul_rem;
	logic [SUM_W-1:0]   sum;
	logic [DIST_W-1:0]  dist_next;
	wls_div_req_t       div_req;
	wls_div_rsp_t       div_rsp;

	assign accept    = req.valid && req.ready;
	assign req.ready = state_q == S_IDLE;
	assign cfg.ready = 1'b1;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign inc_eff   = (inc_q == '0) ? INC_W'(1) : inc_q;

	// start path setup
	always_comb begin
		sx = wls_reduce(src_x_q);
		sy = wls_reduce(src_y_q);
		sz = wls_reduce(src_z_q);
		ex = wls_reduce(dst_x_q);
		ey = wls_reduce(dst_y_q);
		ez = wls_reduce(dst_z_q);
		dx = wls_delta(sx, ex);
		dy = wls_delta(sy, ey);
		dz = wls_delta(sz, ez);
		nowhere = (dx.mag == '0) && (dy.mag == '0) && (dz.mag == '0);
		if (dz.mag >= dx.mag && dz.mag >= dy.mag) begin
			new_major      = AXIS_Z;
			new_major_span = dz.mag;
			new_minor_a    = dx.mag;
			new_minor_b    = dy.mag;
		end else if (dy.mag >= dx.mag && dy.mag >= dz.mag) begin
			new_major      = AXIS_Y;
			new_major_span = dy.mag;
			new_minor_a    = dx.mag;
			new_minor_b    = dz.mag;
		end else begin
			new_major      = AXIS_X;
			new_major_span = dx.mag;
			new_minor_a    = dy.mag;
			new_minor_b    = dz.mag;
		end
	end

	// accumulator feed for the divider
	always_comb begin
		if (state_q == S_DIV_A) begin
			mul_minor = minor_b_q;
			mul_rem   = rem_b_q;
		end else begin
			mul_minor = minor_a_q;
			mul_rem   = rem_a_q;
		end
		sum = SUM_W'(inc_eff) * SUM_W'(mul_minor) + SUM_W'(mul_rem);
		div_req.dividend = sum;
		div_req.divisor  = major_span_q;
		div_req.start    = ((state_q == S_CALC) && (op_q == OP_STEP) && (dist_q != '0)
			&& (major_span_q != '0)) || ((state_q == S_DIV_A) && div_rsp.done);
		dist_next = (dist_q > DIST_W'(inc_eff)) ? dist_q - DIST_W'(inc_eff) : '0;
	end

	wls_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q <= INC_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			inc_q <= cfg.step_increment;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.op;
			src_x_q <= req.src_x;
			src_y_q <= req.src_y;
			src_z_q <= req.src_z;
			dst_x_q <= req.dst_x;
			dst_y_q <= req.dst_y;
			dst_z_q <= req.dst_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.valid && rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			cur_z_q      <= '0;
			major_q      <= AXIS_X;
			signs_q      <= '0;
			major_span_q <= '0;
			minor_a_q    <= '0;
			minor_b_q    <= '0;
			rem_a_q      <= '0;
			rem_b_q      <= '0;
			dist_q       <= '0;
			ma_q         <= '0;
			status_q     <= ST_STARTED;
			last_q       <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (op_q == OP_START) begin
						cur_x_q <= sx;
						cur_y_q <= sy;
						cur_z_q <= sz;
						rem_a_q <= '0;
						rem_b_q <= '0;
						if (nowhere) begin
							dist_q   <= '0;
							status_q <= ST_NOWHERE;
							last_q   <= 1'b1;
						end else begin
							signs_q      <= {dz.neg, dy.neg, dx.neg};
							major_q      <= new_major;
							major_span_q <= new_major_span;
							minor_a_q    <= new_minor_a;
							minor_b_q    <= new_minor_b;
							dist_q       <= DIST_W'(new_major_span);
							status_q     <= ST_STARTED;
							last_q       <= 1'b0;
						end
						state_q <= S_DONE;
					end else if (dist_q == '0 || major_span_q == '0) begin
						dist_q   <= '0;
						status_q <= ST_FINISHED;
						last_q   <= 1'b1;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_DIV_A;
					end
				end
				S_DIV_A: begin
					if (div_rsp.done) begin
						ma_q    <= div_rsp.quot;
						rem_a_q <= div_rsp.rem;
						state_q <= S_DIV_B;
					end
				end
				S_DIV_B: begin
					if (div_rsp.done) begin
						rem_b_q <= div_rsp.rem;
						state_q <= S_MOVE;
						if (major_q == AXIS_Z) begin
							cur_z_q <= wls_move(cur_z_q, inc_eff, signs_q[2]);
							cur_x_q <= wls_move(cur_x_q, ma_q, signs_q[0]);
							cur_y_q <= wls_move(cur_y_q, div_rsp.quot, signs_q[1]);
						end else if (major_q == AXIS_Y) begin
							cur_y_q <= wls_move(cur_y_q, inc_eff, signs_q[1]);
							cur_x_q <= wls_move(cur_x_q, ma_q, signs_q[0]);
							cur_z_q <= wls_move(cur_z_q, div_rsp.quot, signs_q[2]);
						end else begin
							cur_x_q <= wls_move(cur_x_q, inc_eff, signs_q[0]);
							cur_y_q <= wls_move(cur_y_q, ma_q, signs_q[1]);
							cur_z_q <= wls_move(cur_z_q, div_rsp.quot, signs_q[2]);
						end
					end
				end
				S_MOVE: begin
					dist_q   <= dist_next;
					status_q <= ST_STEPPED;
					last_q   <= dist_next == '0;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_x_q      <= cur_x_q;
			out_y_q      <= cur_y_q;
			out_z_q      <= cur_z_q;
			out_status_q <= status_q;
			out_last_q   <= last_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.tile_x    = out_x_q;
	assign rsp.tile_y    = out_y_q;
	assign rsp.tile_z    = out_z_q;
	assign rsp.status    = out_status_q;
	assign rsp.last_step = out_last_q;

endmodule

`default_nettype wire

// File: rtl/wls_div.sv
// ----------------------------------------------------------------------------
// wls_div
// restoring divider, one quotient bit per cycle, shared by both minor axes
// ----------------------------------------------------------------------------
`default_nettype none

module wls_div
	import wls_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire wls_div_req_t req,
	output wls_div_rsp_t      rsp
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]  r_q;
	logic [SUM_W-1:0]  d_q;
	logic [QUOT_W-1:0] q_q;
	logic              fits;

	assign fits = r_q >= d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= req.dividend;
			d_q <= SUM_W'({req.divisor, {(QUOT_W-1){1'b0}}});
			q_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				r_q <= r_q - d_q;
			end
			q_q <= {q_q[QUOT_W-2:0], fits};
			d_q <= d_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = q_q;
	assign rsp.rem  = r_q[SPAN_W-1:0];

endmodule

`default_nettype wire
